/* rtl/bernoulli_naive_bayes_score_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Bernoulli naive Bayes scoring core
// Implication checks that are sampled on the rising clock edge and disabled
// while the synchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef BERNOULLI_NAIVE_BAYES_SCORE_CORE_DEFINES_SVH
`define BERNOULLI_NAIVE_BAYES_SCORE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bnbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BNBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bnbs assertion failed");

`endif

/* rtl/bnbs_pkg.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes scoring package
// Types and fixed constants shared by the scoring core and its arithmetic unit.
// ----------------------------------------------------------------------------
package bnbs_pkg;

    localparam int EXP_W       = 12;
    localparam int PCT_W       = 14;
    localparam int PCT_SCALE   = 10000;
    localparam int PCT_HALF    = 5000;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD     = OUT_TDATA_W - 2 * PCT_W - 1;
    localparam int SHIFT_W     = 8;
    localparam int DIV_W       = 33;
    localparam int ALIGN_LIMIT = 64;

    localparam logic CFG_POS_TOTAL = 1'b0;
    localparam logic CFG_NEG_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GO,
        ST_WAIT,
        ST_ALIGN,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_DIV,
        MDU_NORM,
        MDU_DONE
    } t_mdu_state;

    typedef struct packed {
        logic start;
        logic norm;
    } t_mdu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_sts;

endpackage

/* rtl/bnbs_mdu.sv */
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// Computes floor(mult * num / den) with one shift-add step per cycle, then one
// restoring division step per cycle. In normalizing mode it keeps producing
// fraction bits until the quotient's top bit is set or the shift count saturates, and reports the count.
// ----------------------------------------------------------------------------
module bnbs_mdu #(
    parameter int AW = 32,
    parameter int NW = 20,
    parameter int DW = 33,
    parameter int QW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bnbs_pkg::t_mdu_cmd           i_cmd,
    input  logic [AW-1:0]                i_mult,
    input  logic [NW-1:0]                i_num,
    input  logic [DW-1:0]                i_den,
    output logic [QW-1:0]                o_quo,
    output logic [bnbs_pkg::SHIFT_W-1:0] o_shift,
    output bnbs_pkg::t_mdu_sts           o_sts
);

    localparam int PW = AW + NW;
    localparam int CW = $clog2(PW + 1);

    bnbs_pkg::t_mdu_state r_state;
    bnbs_pkg::t_mdu_state n_state;

    logic [CW-1:0]                r_cnt;
    logic [AW-1:0]                r_mult;
    logic [NW-1:0]                r_num;
    logic [DW-1:0]                r_den;
    logic [PW-1:0]                r_prod;
    logic [DW-1:0]                r_rem;
    logic [QW-1:0]                r_quo;
    logic [bnbs_pkg::SHIFT_W-1:0] r_shift;
    logic                         r_norm;

    logic          div_bit;
    logic [DW:0]   rem_sh;
    logic          div_ge;
    logic [DW-1:0] rem_nx;
    logic [PW-1:0] mul_sum;

    assign div_bit = (r_state == bnbs_pkg::MDU_DIV) ? r_prod[PW-1] : 1'b0;
    assign rem_sh  = {r_rem, div_bit};
    assign div_ge  = rem_sh >= {1'b0, r_den};
    assign rem_nx  = div_ge ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
    assign mul_sum = (r_prod << 1) + (r_num[NW-1] ? PW'(r_mult) : '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnbs_pkg::MDU_IDLE: begin
                if (i_cmd.start) begin
                    n_state = bnbs_pkg::MDU_MUL;
                end
            end
            bnbs_pkg::MDU_MUL: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = bnbs_pkg::MDU_DIV;
                end
            end
            bnbs_pkg::MDU_DIV: begin
                if (r_cnt == CW'(PW - 1)) begin
                    n_state = r_norm ? bnbs_pkg::MDU_NORM : bnbs_pkg::MDU_DONE;
                end
            end
            bnbs_pkg::MDU_NORM: begin
                if (r_quo[QW-1] || (r_shift == '1)) begin
                    n_state = bnbs_pkg::MDU_DONE;
                end
            end
            bnbs_pkg::MDU_DONE: begin
                n_state = bnbs_pkg::MDU_IDLE;
            end
            default: begin
                n_state = bnbs_pkg::MDU_IDLE;
            end
        endcase
    end

    always_comb begin
        o_sts.busy = (r_state != bnbs_pkg::MDU_IDLE);
        o_sts.done = (r_state == bnbs_pkg::MDU_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnbs_pkg::MDU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                bnbs_pkg::MDU_IDLE: begin
                    if (i_cmd.start) begin
                        r_mult  <= i_mult;
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_norm  <= i_cmd.norm;
                        r_prod  <= '0;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_shift <= '0;
                        r_cnt   <= '0;
                    end
                end
                bnbs_pkg::MDU_MUL: begin
                    r_prod <= mul_sum;
                    r_num  <= r_num << 1;
                    r_cnt  <= (r_cnt == CW'(NW - 1)) ? '0 : r_cnt + 1'b1;
                end
                bnbs_pkg::MDU_DIV: begin
                    r_prod <= r_prod << 1;
                    r_rem  <= rem_nx;
                    r_quo  <= {r_quo[QW-2:0], div_ge};
                    r_cnt  <= r_cnt + 1'b1;
                end
                bnbs_pkg::MDU_NORM: begin
                    if (!r_quo[QW-1] && (r_shift != '1)) begin
                        r_rem   <= rem_nx;
                        r_quo   <= {r_quo[QW-2:0], div_ge};
                        r_shift <= r_shift + 1'b1;
                    end
                end
                bnbs_pkg::MDU_DONE: begin
                    r_cnt <= '0;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_quo   = r_quo;
    assign o_shift = r_shift;

endmodule

/* rtl/bernoulli_naive_bayes_score_core.sv */
// ----------------------------------------------------------------------------
// Bernoulli naive Bayes scoring core
// Two-class scorer that keeps one floating running product per class and
// reports both posteriors in hundredths of a percent on the last feature.
// ----------------------------------------------------------------------------
// Each of the first MAX_FEATURES feature transactions of a frame is scaled
// into both class products by one shared multiply-divide unit, one class after
// the other, and the input is not ready until both are done. One scaling is a
// shift-add multiply, a bit-serial division, then up to COUNT_BITS + 1
// normalizing steps. A last feature also applies the two class priors and,
// when both products are nonzero, runs two more divisions for the
// percentages. A result waits in an output register, so a new feature is
// accepted before the result is taken.
module bernoulli_naive_bayes_score_core #(
    parameter int COUNT_BITS    = 20,
    parameter int MANTISSA_BITS = 32,
    parameter int MAX_FEATURES  = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Fields from bit 0: pos_count, neg_count, present, zero fill.
    input  logic [((2*COUNT_BITS+8)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // Fields from bit 0: pos_percent, neg_percent, predict_positive, zero fill.
    output logic [bnbs_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // Fields from bit 0: undefined.
    output logic                                   o_m_axis_tuser,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_addr,
    input  logic [COUNT_BITS-1:0]                  i_cfg_wdata
);

    `include "bernoulli_naive_bayes_score_core_defines.svh"

    localparam int CB   = COUNT_BITS;
    localparam int MB   = MANTISSA_BITS;
    localparam int FC_W = $clog2(MAX_FEATURES + 1);
    localparam int AW   = (MB > 32) ? MB : 32;
    localparam int NW   = (CB > bnbs_pkg::PCT_W) ? CB : bnbs_pkg::PCT_W;
    localparam int DW   = bnbs_pkg::DIV_W;
    localparam int CUT  = (MB > 32) ? (MB - 32) : 0;
    localparam int EW   = bnbs_pkg::EXP_W;
    localparam int PW   = bnbs_pkg::PCT_W;

    localparam logic [MB-1:0]       MANT_ONE = {1'b1, {(MB - 1){1'b0}}};
    localparam logic signed [EW:0]  EXP_LIM  = -(EW + 1)'(2048);

    bnbs_pkg::t_state r_state;
    bnbs_pkg::t_state n_state;

    logic [CB-1:0]        r_cfg_ptot;
    logic [CB-1:0]        r_cfg_ntot;
    logic [1:0]           r_step;
    logic [FC_W-1:0]      r_fcnt;
    logic [CB-1:0]        r_pc;
    logic [CB-1:0]        r_nc;
    logic [CB-1:0]        r_ptot;
    logic [CB-1:0]        r_ntot;
    logic                 r_present;
    logic                 r_last;
    logic [MB-1:0]        r_pm;
    logic [MB-1:0]        r_nm;
    logic signed [EW-1:0] r_pe;
    logic signed [EW-1:0] r_ne;
    logic [31:0]          r_vp;
    logic [31:0]          r_vn;
    logic                 r_pct;
    logic [PW-1:0]        r_pp;
    logic [PW-1:0]        r_np;
    logic                 r_undef;
    logic                 r_ovalid;
    logic [PW-1:0]        r_o_pp;
    logic [PW-1:0]        r_o_np;
    logic                 r_o_pred;
    logic                 r_o_undef;

    logic                 accept;
    logic [CB-1:0]        in_pc;
    logic [CB-1:0]        in_nc;
    logic [CB-1:0]        cfg_pt;
    logic [CB-1:0]        cfg_nt;

    logic                 cls;
    logic                 prior;
    logic [MB-1:0]        cur_m;
    logic signed [EW-1:0] cur_e;
    logic [CB-1:0]        cur_cnt;
    logic [CB-1:0]        cur_tot;
    logic [CB-1:0]        step_num;
    logic [CB:0]          step_den;
    logic                 step_skip;
    logic                 step_zero;
    logic                 step_done;
    logic                 step_end_item;
    logic                 step_final;
    logic signed [EW:0]   e_new;
    logic                 res_zero;

    logic signed [EW:0]   d_exp;
    logic [EW:0]          d_mag;
    logic                 d_neg;
    logic                 d_far;
    logic [5:0]           d_amt;
    logic [MB-1:0]        pv_full;
    logic [MB-1:0]        nv_full;
    logic [31:0]          vp32;
    logic [31:0]          vn32;
    logic [DW-1:0]        pct_sum;
    logic                 out_load;
    logic                 prod_norm;
    logic                 out_pct_ok;

    bnbs_pkg::t_mdu_cmd            mdu_cmd;
    bnbs_pkg::t_mdu_sts            mdu_sts;
    logic [AW-1:0]                 mdu_mult;
    logic [NW-1:0]                 mdu_num;
    logic [DW-1:0]                 mdu_den;
    logic [MB-1:0]                 mdu_quo;
    logic [bnbs_pkg::SHIFT_W-1:0]  mdu_shift;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_pc  = i_s_axis_tdata[CB-1:0];
    assign in_nc  = i_s_axis_tdata[2*CB-1:CB];
    assign cfg_pt = (r_cfg_ptot == '0) ? CB'(1) : r_cfg_ptot;
    assign cfg_nt = (r_cfg_ntot == '0) ? CB'(1) : r_cfg_ntot;

    assign cls      = r_step[0];
    assign prior    = r_step[1];
    assign cur_m    = cls ? r_nm : r_pm;
    assign cur_e    = cls ? r_ne : r_pe;
    assign cur_cnt  = cls ? r_nc : r_pc;
    assign cur_tot  = cls ? r_ntot : r_ptot;
    assign step_num = prior ? cur_tot : (r_present ? cur_cnt : (cur_tot - cur_cnt));
    assign step_den = prior ? ({1'b0, r_ptot} + {1'b0, r_ntot}) : {1'b0, cur_tot};
    assign step_skip = !prior && (r_fcnt >= FC_W'(MAX_FEATURES));
    assign step_zero = (cur_m == '0) || (step_num == '0);
    assign step_done = ((r_state == bnbs_pkg::ST_GO) && (step_skip || step_zero))
                    || ((r_state == bnbs_pkg::ST_WAIT) && mdu_sts.done);
    assign step_end_item = (r_step == 2'd1) && !r_last;
    assign step_final    = (r_step == 2'd3);

    assign e_new    = $signed({cur_e[EW-1], cur_e}) - $signed({5'b0, mdu_shift});
    assign res_zero = (e_new < EXP_LIM) || !mdu_quo[MB-1];

    assign d_exp   = $signed({r_pe[EW-1], r_pe}) - $signed({r_ne[EW-1], r_ne});
    assign d_neg   = d_exp[EW];
    assign d_mag   = d_neg ? (EW + 1)'(-d_exp) : d_exp;
    assign d_far   = d_mag >= (EW + 1)'(bnbs_pkg::ALIGN_LIMIT);
    assign d_amt   = d_mag[5:0];
    assign pv_full = (d_neg && d_far) ? '0 : (d_neg ? (r_pm >> d_amt) : r_pm);
    assign nv_full = (!d_neg && d_far) ? '0 : (!d_neg ? (r_nm >> d_amt) : r_nm);
    assign vp32    = 32'(pv_full >> CUT);
    assign vn32    = 32'(nv_full >> CUT);
    assign pct_sum = DW'(r_vp) + DW'(r_vn);

    assign out_load = (r_state == bnbs_pkg::ST_OUT) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        if (r_state == bnbs_pkg::ST_PCT_GO) begin
            mdu_mult = AW'(r_pct ? r_vn : r_vp);
            mdu_num  = NW'(bnbs_pkg::PCT_SCALE);
            mdu_den  = pct_sum;
        end else begin
            mdu_mult = AW'(cur_m);
            mdu_num  = NW'(step_num);
            mdu_den  = DW'(step_den);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnbs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bnbs_pkg::ST_GO;
                end
            end
            bnbs_pkg::ST_GO, bnbs_pkg::ST_WAIT: begin
                if (step_done) begin
                    if (step_end_item) begin
                        n_state = bnbs_pkg::ST_IDLE;
                    end else if (step_final) begin
                        n_state = bnbs_pkg::ST_ALIGN;
                    end else begin
                        n_state = bnbs_pkg::ST_GO;
                    end
                end else if (r_state == bnbs_pkg::ST_GO) begin
                    n_state = bnbs_pkg::ST_WAIT;
                end
            end
            bnbs_pkg::ST_ALIGN: begin
                if ((r_pm != '0) && (r_nm != '0)) begin
                    n_state = bnbs_pkg::ST_PCT_GO;
                end else begin
                    n_state = bnbs_pkg::ST_OUT;
                end
            end
            bnbs_pkg::ST_PCT_GO: begin
                n_state = bnbs_pkg::ST_PCT_WAIT;
            end
            bnbs_pkg::ST_PCT_WAIT: begin
                if (mdu_sts.done) begin
                    n_state = r_pct ? bnbs_pkg::ST_OUT : bnbs_pkg::ST_PCT_GO;
                end
            end
            bnbs_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = bnbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bnbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == bnbs_pkg::ST_IDLE);
        mdu_cmd.start   = ((r_state == bnbs_pkg::ST_GO) && !step_skip && !step_zero)
                       || (r_state == bnbs_pkg::ST_PCT_GO);
        mdu_cmd.norm    = (r_state == bnbs_pkg::ST_GO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bnbs_pkg::ST_IDLE;
            r_cfg_ptot <= CB'(1);
            r_cfg_ntot <= CB'(1);
            r_step     <= '0;
            r_fcnt     <= '0;
            r_pm       <= MANT_ONE;
            r_nm       <= MANT_ONE;
            r_pe       <= '0;
            r_ne       <= '0;
            r_pct      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bnbs_pkg::CFG_POS_TOTAL: r_cfg_ptot <= i_cfg_wdata;
                    bnbs_pkg::CFG_NEG_TOTAL: r_cfg_ntot <= i_cfg_wdata;
                    default: r_cfg_ptot <= r_cfg_ptot;
                endcase
            end

            if (accept) begin
                r_ptot    <= cfg_pt;
                r_ntot    <= cfg_nt;
                r_pc      <= (in_pc > cfg_pt) ? cfg_pt : in_pc;
                r_nc      <= (in_nc > cfg_nt) ? cfg_nt : in_nc;
                r_present <= i_s_axis_tdata[2*CB];
                r_last    <= i_s_axis_tlast;
                r_step    <= '0;
            end

            if (step_done) begin
                if (!step_skip) begin
                    if ((r_state == bnbs_pkg::ST_GO) || res_zero) begin
                        if (cls) begin
                            r_nm <= '0;
                            r_ne <= '0;
                        end else begin
                            r_pm <= '0;
                            r_pe <= '0;
                        end
                    end else begin
                        if (cls) begin
                            r_nm <= mdu_quo;
                            r_ne <= e_new[EW-1:0];
                        end else begin
                            r_pm <= mdu_quo;
                            r_pe <= e_new[EW-1:0];
                        end
                    end
                    if (r_step == 2'd1) begin
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                end
                r_step <= r_step + 1'b1;
            end

            if (r_state == bnbs_pkg::ST_ALIGN) begin
                r_vp  <= vp32;
                r_vn  <= vn32;
                r_pct <= 1'b0;
                if ((r_pm == '0) && (r_nm == '0)) begin
                    r_undef <= 1'b1;
                    r_pp    <= '0;
                    r_np    <= '0;
                end else if (r_nm == '0) begin
                    r_undef <= 1'b0;
                    r_pp    <= PW'(bnbs_pkg::PCT_SCALE);
                    r_np    <= '0;
                end else if (r_pm == '0) begin
                    r_undef <= 1'b0;
                    r_pp    <= '0;
                    r_np    <= PW'(bnbs_pkg::PCT_SCALE);
                end else begin
                    r_undef <= 1'b0;
                end
            end

            if ((r_state == bnbs_pkg::ST_PCT_WAIT) && mdu_sts.done) begin
                if (r_pct) begin
                    r_np <= mdu_quo[PW-1:0];
                end else begin
                    r_pp  <= mdu_quo[PW-1:0];
                    r_pct <= 1'b1;
                end
            end

            if (out_load) begin
                r_o_pp    <= r_pp;
                r_o_np    <= r_np;
                r_o_pred  <= r_pp > PW'(bnbs_pkg::PCT_HALF);
                r_o_undef <= r_undef;
                r_ovalid  <= 1'b1;
                r_pm      <= MANT_ONE;
                r_nm      <= MANT_ONE;
                r_pe      <= '0;
                r_ne      <= '0;
                r_fcnt    <= '0;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    bnbs_mdu #(
        .AW (AW),
        .NW (NW),
        .DW (DW),
        .QW (MB)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mdu_cmd),
        .i_mult  (mdu_mult),
        .i_num   (mdu_num),
        .i_den   (mdu_den),
        .o_quo   (mdu_quo),
        .o_shift (mdu_shift),
        .o_sts   (mdu_sts)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{bnbs_pkg::OUT_PAD{1'b0}}, r_o_pred, r_o_np, r_o_pp};
    assign o_m_axis_tuser  = r_o_undef;

    assign prod_norm  = ((r_pm == '0) || r_pm[MB-1]) && ((r_nm == '0) || r_nm[MB-1]);
    assign out_pct_ok = ((PW + 1)'(r_o_pp) + (PW + 1)'(r_o_np))
                     <= (PW + 1)'(bnbs_pkg::PCT_SCALE);

    `BNBS_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, accept, !o_s_axis_tready)
    `BNBS_ASSERT_IMP(a_ready_unit_idle, i_clk, i_rst_n, o_s_axis_tready, !mdu_sts.busy)
    `BNBS_ASSERT_IMP(a_products_normalized, i_clk, i_rst_n, 1'b1, prod_norm)
    `BNBS_ASSERT_IMP(a_percent_sum, i_clk, i_rst_n, r_ovalid, out_pct_ok)

endmodule

/* tb/bnbs_score_checker.sv */
// ----------------------------------------------------------------------------
// Scoring checker for the Bernoulli naive Bayes core
// Watches the feature, result and register-write ports, keeps its own copy of
// both class products and totals, and compares each result transaction with
// the oldest predicted score.
// ----------------------------------------------------------------------------
module bnbs_score_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // Fields from bit 0: pos_count, neg_count, present, zero fill.
    input  logic [47:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: pos_percent, neg_percent, predict_positive, zero fill.
    input  logic [31:0] i_m_tdata,
    // Fields from bit 0: undefined.
    input  logic        i_m_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [19:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_features,
    output int          o_scores,
    output int          o_undefined
);

    localparam int                 FEATURE_LIMIT = 64;
    localparam int                 EXP_FLOOR     = -2048;
    localparam longint unsigned    MANT_ONE      = 64'h8000_0000;

    typedef struct {
        logic [bnbs_pkg::PCT_W-1:0] pos_pct;
        logic [bnbs_pkg::PCT_W-1:0] neg_pct;
        logic                       predict;
        logic                       undef;
    } t_score;

    t_score            score_q[$];
    longint unsigned   pos_total, neg_total;
    longint unsigned   pos_mant, neg_mant;
    int                pos_exp, neg_exp;
    int                feature_cnt;

    function automatic void scale_product(inout longint unsigned mant, inout int expo,
                                          input longint unsigned num,
                                          input longint unsigned den);
        longint unsigned prod, quo, rem;
        int              shift;
        if (mant == 0 || num == 0 || den == 0) begin
            mant = 0;
            expo = 0;
            return;
        end
        prod  = mant * num;
        quo   = prod / den;
        rem   = prod % den;
        shift = 0;
        while (quo < MANT_ONE && shift < 128) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
            shift++;
        end
        if (expo - shift < EXP_FLOOR || quo < MANT_ONE) begin
            mant = 0;
            expo = 0;
        end else begin
            mant = quo;
            expo = expo - shift;
        end
    endfunction

    function automatic void restart_products();
        pos_mant    = MANT_ONE;
        neg_mant    = MANT_ONE;
        pos_exp     = 0;
        neg_exp     = 0;
        feature_cnt = 0;
    endfunction

    function automatic void score_feature(input logic [19:0] pc_in, input logic [19:0] nc_in,
                                          input logic present, input logic last);
        longint unsigned ptot, ntot, pc, nc, vp, vn, pp, np;
        int              d;
        t_score          s;
        ptot = (pos_total == 0) ? 1 : pos_total;
        ntot = (neg_total == 0) ? 1 : neg_total;
        pc   = (pc_in > ptot) ? ptot : pc_in;
        nc   = (nc_in > ntot) ? ntot : nc_in;
        if (feature_cnt < FEATURE_LIMIT) begin
            scale_product(pos_mant, pos_exp, present ? pc : ptot - pc, ptot);
            scale_product(neg_mant, neg_exp, present ? nc : ntot - nc, ntot);
            feature_cnt++;
        end
        if (!last) return;
        scale_product(pos_mant, pos_exp, ptot, ptot + ntot);
        scale_product(neg_mant, neg_exp, ntot, ptot + ntot);
        pp = 0;
        np = 0;
        s.undef = 1'b0;
        if (pos_mant == 0 && neg_mant == 0) begin
            s.undef = 1'b1;
        end else if (neg_mant == 0) begin
            pp = bnbs_pkg::PCT_SCALE;
        end else if (pos_mant == 0) begin
            np = bnbs_pkg::PCT_SCALE;
        end else begin
            vp = pos_mant;
            vn = neg_mant;
            d  = pos_exp - neg_exp;
            if (d >= 0) vn = (d >= bnbs_pkg::ALIGN_LIMIT) ? 0 : (vn >> d);
            else        vp = (-d >= bnbs_pkg::ALIGN_LIMIT) ? 0 : (vp >> (-d));
            pp = (vp * bnbs_pkg::PCT_SCALE) / (vp + vn);
            np = (vn * bnbs_pkg::PCT_SCALE) / (vp + vn);
        end
        s.pos_pct = pp[bnbs_pkg::PCT_W-1:0];
        s.neg_pct = np[bnbs_pkg::PCT_W-1:0];
        s.predict = (pp > bnbs_pkg::PCT_HALF);
        score_q.push_back(s);
        restart_products();
    endfunction

    assign o_pending = score_q.size();

    always @(posedge i_clk) begin
        t_score s;
        if (!i_rst_n) begin
            pos_total   = 1;
            neg_total   = 1;
            restart_products();
            score_q.delete();
            o_errors    = 0;
            o_features  = 0;
            o_scores    = 0;
            o_undefined = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_scores++;
                if (i_m_tuser) o_undefined++;
                if (score_q.size() == 0) begin
                    $error("result transaction with no score expected");
                    o_errors++;
                end else begin
                    s = score_q.pop_front();
                    if (i_m_tdata[13:0] !== s.pos_pct) begin
                        $error("pos_percent: expected %0d, got %0d", s.pos_pct,
                               i_m_tdata[13:0]);
                        o_errors++;
                    end
                    if (i_m_tdata[27:14] !== s.neg_pct) begin
                        $error("neg_percent: expected %0d, got %0d", s.neg_pct,
                               i_m_tdata[27:14]);
                        o_errors++;
                    end
                    if (i_m_tdata[28] !== s.predict) begin
                        $error("predict_positive: expected %0d, got %0d", s.predict,
                               i_m_tdata[28]);
                        o_errors++;
                    end
                    if (i_m_tuser !== s.undef) begin
                        $error("undefined: expected %0d, got %0d", s.undef, i_m_tuser);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                o_features++;
                score_feature(i_s_tdata[19:0], i_s_tdata[39:20], i_s_tdata[40], i_s_tlast);
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == bnbs_pkg::CFG_POS_TOTAL) pos_total = i_cfg_wdata;
                else                                       neg_total = i_cfg_wdata;
            end
        end
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the Bernoulli naive Bayes scoring core
// Drives directed and random feature frames under several class totals, with
// random gaps and stalls and one long result hold-off; the checker predicts
// and compares every score.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 600;
    localparam int PHASE_ITEMS  = 72;
    localparam int HOLD_CYCLES  = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [47:0] s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    logic        m_user;
    logic        cfg_we;
    logic        cfg_addr;
    logic [19:0] cfg_wdata;
    int          errors, pending, features, scores, undef_cnt;
    bit          quiet;
    int          cycles;

    bernoulli_naive_bayes_score_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    bnbs_score_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tlast   (s_last),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tuser   (m_user),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_features  (features),
        .o_scores    (scores),
        .o_undefined (undef_cnt)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_feature(input logic [19:0] pc, input logic [19:0] nc,
                                input logic present, input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {7'd0, present, nc, pc};
        s_last  = last;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        s_valid = 1'b0;
    endtask

    task automatic write_total(input logic addr, input logic [19:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [19:0] pick_count(input int unsigned tot);
        case ($urandom_range(0, 7))
            0:       return 20'd0;
            1:       return tot[19:0];
            2:       return 20'($urandom());
            default: return 20'($urandom_range(0, tot));
        endcase
    endfunction

    task automatic random_frames(input int unsigned ptot, input int unsigned ntot,
                                 input int items, input bit long_frame);
        int sent, len, k;
        sent = 0;
        while (sent < items) begin
            len = long_frame ? $urandom_range(65, 70) : $urandom_range(1, 6);
            long_frame = 0;
            for (k = 0; k < len; k++) begin
                send_feature(pick_count(ptot), pick_count(ntot),
                             1'($urandom_range(0, 1)), k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        int unsigned burst;
        bit          held;
        burst   = 0;
        held    = 0;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && scores >= 15) begin
                held    = 1;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (quiet) begin
                m_ready = 1'b1;
            end else if (burst > 0) begin
                m_ready = 1'b0;
                burst--;
            end else if ($urandom_range(0, 3) == 0) begin
                burst   = $urandom_range(0, 4);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        int unsigned ptot[7];
        int unsigned ntot[7];
        int          ph;
        ptot = '{1, 1048575, 1, 1048575, 0, 2, 1};
        ntot = '{1, 1048575, 1048575, 1, 0, 3, 1};
        ptot[6] = $urandom_range(1, 1048575);
        ntot[6] = $urandom_range(1, 1048575);
        quiet     = 0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_last    = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = bnbs_pkg::CFG_POS_TOTAL;
        cfg_wdata = '0;
        i_rst_n   = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_feature(20'd0, 20'd0, 1'b0, 1'b1);
        send_feature(20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
        send_feature(20'd0, 20'd1, 1'b1, 1'b1);
        send_feature(20'd1, 20'd0, 1'b1, 1'b1);
        send_feature(20'd0, 20'd0, 1'b1, 1'b1);
        random_frames(ptot[0], ntot[0], PHASE_ITEMS - 5, 0);

        for (ph = 1; ph < 7; ph++) begin
            drain();
            write_total(bnbs_pkg::CFG_POS_TOTAL, 20'(ptot[ph]));
            write_total(bnbs_pkg::CFG_NEG_TOTAL, 20'(ntot[ph]));
            if (ph == 1) begin
                send_feature(20'hFFFFF, 20'd0, 1'b1, 1'b0);
                send_feature(20'd0, 20'hFFFFF, 1'b0, 1'b0);
                send_feature(20'd12345, 20'd678, 1'b1, 1'b1);
                send_feature(20'd1, 20'hFFFFF, 1'b1, 1'b1);
                send_feature(20'hFFFFF, 20'd1, 1'b0, 1'b1);
            end
            if (ph == 6) quiet = 1;
            random_frames(ptot[ph], ntot[ph], PHASE_ITEMS, ph == 1 || ph == 3);
        end
        drain();

        $display("Covered %0d feature transactions and %0d scores (%0d undefined)",
                 features, scores, undef_cnt);
        $display("under seven total settings, including zero and both extremes.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/bnbs_pkg.sv
rtl/bnbs_mdu.sv
rtl/bernoulli_naive_bayes_score_core.sv
tb/bnbs_score_checker.sv
tb/testbench.sv
